>>> sv/uvs_pkg.sv
// Shared types, mesh constants and elaboration-time trig tables for the UV sphere generator.
package uvs_pkg;

  localparam int STACKS = 80;
  localparam int SLICES = 40;
  localparam int RING   = SLICES + 1;
  localparam int SOUTH  = 1 + (STACKS - 1) * RING;
  localparam int PHI_N   = 2 * STACKS;
  localparam int THETA_N = SLICES;
  localparam longint PI_HALF_Q30 = 64'd1686629713;
  localparam longint ONE_Q30     = 64'd1073741824;

  localparam int PHI_IDX_W   = $clog2(STACKS + 1);
  localparam int THETA_IDX_W = $clog2(SLICES + 1);

  localparam logic signed [15:0] Q14_ONE = 16'sd16384;

  typedef enum logic {
    CMD_VERTEX   = 1'b0,
    CMD_TRIANGLE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    TRI_TOP = 2'd0,
    TRI_MID = 2'd1,
    TRI_BOT = 2'd2
  } tri_cls_e;

  typedef struct packed {
    logic signed [15:0] s;
    logic signed [15:0] c;
  } sc_t;

  typedef sc_t [0:STACKS] phi_tab_t;
  typedef sc_t [0:SLICES] theta_tab_t;

  function automatic longint mul30(longint a, longint b);
    return (a * b + 64'd536870912) >>> 30;
  endfunction

  function automatic longint sin_series(longint x);
    longint x2, p3, p5, p7, p9;
    x2 = mul30(x, x);
    p3 = mul30(x, x2);
    p5 = mul30(p3, x2);
    p7 = mul30(p5, x2);
    p9 = mul30(p7, x2);
    return x - p3 / 6 + p5 / 120 - p7 / 5040 + p9 / 362880;
  endfunction

  function automatic longint cos_series(longint x);
    longint x2, p4, p6, p8, p10;
    x2  = mul30(x, x);
    p4  = mul30(x2, x2);
    p6  = mul30(p4, x2);
    p8  = mul30(p6, x2);
    p10 = mul30(p8, x2);
    return ONE_Q30 - x2 / 2 + p4 / 24 - p6 / 720 + p8 / 40320 - p10 / 3628800;
  endfunction

  function automatic logic signed [15:0] to_q14(longint v);
    longint r;
    if (v < 0) begin
      v = 0;
    end
    r = (v + 32768) >>> 16;
    if (r > 16384) begin
      r = 16384;
    end
    return 16'(r);
  endfunction

  // Divide by the angle step count of either table.
  function automatic longint div_n(longint v, bit phi);
    return phi ? v / PHI_N : v / THETA_N;
  endfunction

  // Sine and cosine of 2*pi*k/n in Q1.14, n picked by phi.
  function automatic sc_t trig_q14(int k, bit phi);
    longint n, m, q, rem, x;
    logic signed [15:0] a, b;
    sc_t r;
    n   = phi ? longint'(PHI_N) : longint'(THETA_N);
    m   = phi ? longint'(k % PHI_N) : longint'(k % THETA_N);
    q   = div_n(4 * m, phi);
    rem = 4 * m - q * n;
    if (2 * rem <= n) begin
      x = div_n(PI_HALF_Q30 * rem + n / 2, phi);
      a = to_q14(sin_series(x));
      b = to_q14(cos_series(x));
    end else begin
      x = div_n(PI_HALF_Q30 * (n - rem) + n / 2, phi);
      a = to_q14(cos_series(x));
      b = to_q14(sin_series(x));
    end
    case (q[1:0])
      2'd0: begin r.s = a;  r.c = b;  end
      2'd1: begin r.s = b;  r.c = -a; end
      2'd2: begin r.s = -a; r.c = -b; end
      default: begin r.s = -b; r.c = a; end
    endcase
    return r;
  endfunction

  function automatic phi_tab_t build_phi_tab();
    phi_tab_t t;
    for (int k = 0; k <= STACKS; k++) begin
      t[k] = trig_q14(k, 1'b1);
    end
    return t;
  endfunction

  function automatic theta_tab_t build_theta_tab();
    theta_tab_t t;
    for (int k = 0; k <= SLICES; k++) begin
      t[k] = trig_q14(k, 1'b0);
    end
    return t;
  endfunction

  localparam phi_tab_t   PHI_TAB   = build_phi_tab();
  localparam theta_tab_t THETA_TAB = build_theta_tab();

  // Q1.14 product, rounded half away from zero.
  function automatic logic signed [15:0] mul_q14(logic signed [15:0] a, logic signed [15:0] b);
    logic [15:0] ua, ub;
    logic [31:0] p;
    logic [15:0] m;
    ua = a[15] ? 16'(-a) : 16'(a);
    ub = b[15] ? 16'(-b) : 16'(b);
    p  = 32'(ua) * 32'(ub) + 32'd8192;
    m  = p[29:14];
    return (a[15] ^ b[15]) ? -$signed(m) : $signed(m);
  endfunction

  // Q8.8 radius times Q1.14 component, rounded half away from zero.
  function automatic logic signed [16:0] scale_pos(logic [15:0] r, logic signed [15:0] n);
    logic [15:0] un;
    logic [31:0] p;
    logic [16:0] m;
    un = n[15] ? 16'(-n) : 16'(n);
    p  = 32'(r) * 32'(un) + 32'd8192;
    m  = p[30:14];
    return n[15] ? -$signed(m) : $signed(m);
  endfunction

endpackage

>>> sv/uv_sphere_mesh_generator_top.sv
// UV sphere mesh generator: vertex and triangle requests in, one mesh element out per request.
// Each request yields exactly one result after three register stages (table lookup and range
// check, normal product and corner indices, radius scaling); a new request enters every clock
// cycle, so the sustained rate is one item per cycle and only back pressure on the result
// channel slows it. The sine and cosine tables are constants built at elaboration, so there is
// no clearing pass after reset. The radius register (unsigned Q8.8, reset 1.0) is written over
// the cfg channel, by the user only while no request is in flight; no check enforces this.
module uv_sphere_mesh_generator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i,     // radius
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // band[6:0], slice[12:7], half[13], zero pad
  input  logic         s_axis_tuser,   // command
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z (17 b each), normal_x, normal_y, normal_z (16 b each),
  // corner_a, corner_b, corner_c (12 b each), one zero pad bit
  output logic [135:0] m_axis_tdata,
  output logic         m_axis_tuser    // error
);
  import uvs_pkg::*;

  logic [15:0] radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
    end else if (cfg_valid_i) begin
      radius_q <= cfg_data_i;
    end
  end

  // Stall chain: a stage loads when empty or when the next one loads.
  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  assign en3 = !v3_q || m_axis_tready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= s_axis_tvalid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  // ---------------- stage 1: decode, range check, table lookup ----------------
  logic       in_cmd;
  logic [6:0] in_band;
  logic [5:0] in_slice;
  logic       in_half;

  assign in_cmd   = s_axis_tuser;
  assign in_band  = s_axis_tdata[6:0];
  assign in_slice = s_axis_tdata[12:7];
  assign in_half  = s_axis_tdata[13];

  logic                   top_pole_d, bot_pole_d, inner_d;
  logic                   err_d;
  logic [PHI_IDX_W-1:0]   phi_idx;
  logic [THETA_IDX_W-1:0] theta_idx;
  tri_cls_e               cls_d;
  logic [11:0]            row_d;

  always_comb begin
    top_pole_d = (in_band == 7'd0);
    bot_pole_d = (in_band == 7'(STACKS));
    inner_d    = !top_pole_d && !bot_pole_d;
    if (in_cmd == CMD_VERTEX) begin
      err_d = (in_band > 7'(STACKS)) || (inner_d && (in_slice > 6'(SLICES)));
    end else begin
      err_d = (in_band > 7'(STACKS - 1)) || (in_slice >= 6'(SLICES));
    end
    phi_idx   = (in_band <= 7'(STACKS)) ? PHI_IDX_W'(in_band) : '0;
    theta_idx = (in_slice <= 6'(SLICES)) ? THETA_IDX_W'(in_slice) : '0;
    if (in_band == 7'd0) begin
      cls_d = TRI_TOP;
    end else if (in_band == 7'(STACKS - 1)) begin
      cls_d = TRI_BOT;
    end else begin
      cls_d = TRI_MID;
    end
    row_d = 12'(({5'd0, in_band} - 12'd1) * 12'(RING)) + 12'd1;
  end

  logic        cmd1_q, err1_q, top1_q, bot1_q, half1_q;
  sc_t         phi1_q, theta1_q;
  tri_cls_e    cls1_q;
  logic [11:0] row1_q;
  logic [5:0]  slice1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cmd1_q   <= in_cmd;
      err1_q   <= err_d;
      top1_q   <= top_pole_d;
      bot1_q   <= bot_pole_d;
      half1_q  <= in_half;
      phi1_q   <= PHI_TAB[phi_idx];
      theta1_q <= THETA_TAB[theta_idx];
      cls1_q   <= cls_d;
      row1_q   <= row_d;
      slice1_q <= in_slice;
    end
  end

  // ---------------- stage 2: normal products, corner indices ----------------
  logic signed [15:0] nx_d, ny_d, nz_d;
  logic [11:0]        ca_d, cb_d, cc_d;
  logic [11:0]        j, r0, r1;

  always_comb begin
    j  = {6'd0, slice1_q};
    r0 = row1_q;
    r1 = row1_q + 12'(RING);
    nx_d = '0;
    ny_d = '0;
    nz_d = '0;
    ca_d = '0;
    cb_d = '0;
    cc_d = '0;
    if (!err1_q && cmd1_q == CMD_VERTEX) begin
      if (top1_q) begin
        ny_d = Q14_ONE;
      end else if (bot1_q) begin
        ny_d = -Q14_ONE;
      end else begin
        nx_d = mul_q14(phi1_q.s, theta1_q.c);
        ny_d = phi1_q.c;
        nz_d = mul_q14(phi1_q.s, theta1_q.s);
      end
    end else if (!err1_q) begin
      case (cls1_q)
        TRI_TOP: begin
          cb_d = j + 12'd2;
          cc_d = j + 12'd1;
        end
        TRI_BOT: begin
          ca_d = 12'(SOUTH);
          cb_d = 12'(SOUTH - RING) + j;
          cc_d = 12'(SOUTH - RING) + j + 12'd1;
        end
        default: begin
          if (!half1_q) begin
            ca_d = r0 + j;
            cb_d = r0 + j + 12'd1;
            cc_d = r1 + j;
          end else begin
            ca_d = r1 + j;
            cb_d = r0 + j + 12'd1;
            cc_d = r1 + j + 12'd1;
          end
        end
      endcase
    end
  end

  logic               err2_q;
  logic signed [15:0] nx2_q, ny2_q, nz2_q;
  logic [11:0]        ca2_q, cb2_q, cc2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      err2_q <= err1_q;
      nx2_q  <= nx_d;
      ny2_q  <= ny_d;
      nz2_q  <= nz_d;
      ca2_q  <= ca_d;
      cb2_q  <= cb_d;
      cc2_q  <= cc_d;
    end
  end

  // ---------------- stage 3: radius scaling, output register ----------------
  logic               err3_q;
  logic signed [16:0] px3_q, py3_q, pz3_q;
  logic signed [15:0] nx3_q, ny3_q, nz3_q;
  logic [11:0]        ca3_q, cb3_q, cc3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      err3_q <= err2_q;
      px3_q  <= scale_pos(radius_q, nx2_q);
      py3_q  <= scale_pos(radius_q, ny2_q);
      pz3_q  <= scale_pos(radius_q, nz2_q);
      nx3_q  <= nx2_q;
      ny3_q  <= ny2_q;
      nz3_q  <= nz2_q;
      ca3_q  <= ca2_q;
      cb3_q  <= cb2_q;
      cc3_q  <= cc2_q;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tuser  = err3_q;
  assign m_axis_tdata  = {1'b0, cc3_q, cb3_q, ca3_q, nz3_q, ny3_q, nx3_q,
                          pz3_q, py3_q, px3_q};

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("error result carries nonzero payload");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && v2_q && v3_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while pipeline is full and stalled");

  a_tri_no_geom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && (ca2_q != '0 || cb2_q != '0 || cc2_q != '0) |->
      nx2_q == '0 && ny2_q == '0 && nz2_q == '0)
    else $error("triangle result carries a normal");

  a_normal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> ny2_q <= Q14_ONE && ny2_q >= -Q14_ONE && nx2_q <= Q14_ONE && nx2_q >= -Q14_ONE)
    else $error("normal component outside unit range");
`endif

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the UV sphere mesh generator: random request streams with a scoreboard.
`timescale 1ns / 100ps

module testbench;
  import uvs_pkg::*;

  localparam int FIELD_COUNT = 10;
  // Bit positions in {error, tdata}: three positions, three normals, three corners, error.
  localparam int FIELD_LSB [FIELD_COUNT] = '{0, 17, 34, 51, 67, 83, 99, 111, 123, 136};
  localparam int FIELD_W   [FIELD_COUNT] = '{17, 17, 17, 16, 16, 16, 12, 12, 12, 1};
  localparam longint QUARTER_TURN_Q30 = 64'd1686629713;
  localparam int ITEMS_PER_PHASE = 310;
  localparam int PHASES = 6;

  typedef struct packed {
    cmd_e       cmd;
    logic [6:0] band;
    logic [5:0] slice;
    logic       half;
  } mesh_req_t;

  typedef struct {
    mesh_req_t    req;
    logic [136:0] word;
  } mesh_expect_t;

  class mesh_scoreboard;
    logic [15:0]  radius;
    mesh_expect_t expected_q[$];
    int mismatches;
    int compared;
    int n_vertex;
    int n_triangle;
    int n_error;
    string field_name [FIELD_COUNT];

    function new();
      radius = 16'd256;
      mismatches = 0;
      compared = 0;
      n_vertex = 0;
      n_triangle = 0;
      n_error = 0;
      field_name = '{"pos_x", "pos_y", "pos_z", "normal_x", "normal_y", "normal_z",
                     "corner_a", "corner_b", "corner_c", "error"};
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function longint q30_product(longint a, longint b);
      return (a * b + 64'd536870912) >>> 30;
    endfunction

    function longint sine_poly(longint x);
      longint x2, p3, p5, p7, p9;
      x2 = q30_product(x, x);
      p3 = q30_product(x, x2);
      p5 = q30_product(p3, x2);
      p7 = q30_product(p5, x2);
      p9 = q30_product(p7, x2);
      return x - p3 / 6 + p5 / 120 - p7 / 5040 + p9 / 362880;
    endfunction

    function longint cosine_poly(longint x);
      longint x2, p4, p6, p8, p10;
      x2  = q30_product(x, x);
      p4  = q30_product(x2, x2);
      p6  = q30_product(p4, x2);
      p8  = q30_product(p6, x2);
      p10 = q30_product(p8, x2);
      return 64'd1073741824 - x2 / 2 + p4 / 24 - p6 / 720 + p8 / 40320 - p10 / 3628800;
    endfunction

    function int q30_to_q14(longint v);
      longint r;
      if (v < 0) begin
        v = 0;
      end
      r = (v + 32768) / 65536;
      return (r > 16384) ? 16384 : int'(r);
    endfunction

    // Sine and cosine of 2*pi*k/n at Q1.14, folded from the first octant.
    function void unit_circle(int k, int n, output int s, output int c);
      longint m, q, rem, x;
      int a, b;
      m   = k % n;
      q   = (4 * m) / n;
      rem = 4 * m - q * n;
      if (2 * rem <= n) begin
        x = (QUARTER_TURN_Q30 * rem + n / 2) / n;
        a = q30_to_q14(sine_poly(x));
        b = q30_to_q14(cosine_poly(x));
      end else begin
        x = (QUARTER_TURN_Q30 * (n - rem) + n / 2) / n;
        a = q30_to_q14(cosine_poly(x));
        b = q30_to_q14(sine_poly(x));
      end
      case (q % 4)
        0: begin s = a;  c = b;  end
        1: begin s = b;  c = -a; end
        2: begin s = -a; c = -b; end
        default: begin s = -b; c = a; end
      endcase
    endfunction

    function longint round_mul14(longint a, longint b);
      bit neg;
      longint ua, ub, m;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      m = (ua * ub + 8192) >>> 14;
      return neg ? -m : m;
    endfunction

    function logic [136:0] mesh_element(mesh_req_t req);
      longint f [FIELD_COUNT];
      int sp, cp, st, ct;
      int b, s;
      longint row, south, base;
      for (int i = 0; i < FIELD_COUNT; i++) begin
        f[i] = 0;
      end
      b = int'(req.band);
      s = int'(req.slice);
      south = 1 + (STACKS - 1) * (SLICES + 1);
      if (req.cmd == CMD_VERTEX) begin
        if (b > STACKS || (b != 0 && b != STACKS && s > SLICES)) begin
          f[9] = 1;
        end else begin
          // Poles ignore the slice entirely.
          if (b == 0 || b == STACKS) begin
            f[4] = (b == 0) ? 16384 : -16384;
          end else begin
            unit_circle(b, 2 * STACKS, sp, cp);
            unit_circle(s, SLICES, st, ct);
            f[3] = round_mul14(sp, ct);
            f[4] = cp;
            f[5] = round_mul14(sp, st);
          end
          for (int i = 0; i < 3; i++) begin
            f[i] = round_mul14(longint'(radius), f[i + 3]);
          end
        end
      end else begin
        if (b > STACKS - 1 || s >= SLICES) begin
          f[9] = 1;
        end else if (b == 0) begin
          f[7] = s + 2;
          f[8] = s + 1;
        end else if (b == STACKS - 1) begin
          base = south - (SLICES + 1);
          f[6] = south;
          f[7] = base + s;
          f[8] = base + s + 1;
        end else begin
          row = 1 + (b - 1) * (SLICES + 1);
          if (!req.half) begin
            f[6] = row + s;
            f[7] = row + s + 1;
            f[8] = row + SLICES + 1 + s;
          end else begin
            f[6] = row + SLICES + 1 + s;
            f[7] = row + s + 1;
            f[8] = row + SLICES + 2 + s;
          end
        end
      end
      return {f[9][0], 1'b0, f[8][11:0], f[7][11:0], f[6][11:0], f[5][15:0], f[4][15:0],
              f[3][15:0], f[2][16:0], f[1][16:0], f[0][16:0]};
    endfunction

    function void note_request(mesh_req_t req);
      mesh_expect_t e;
      e.req  = req;
      e.word = mesh_element(req);
      if (req.cmd == CMD_VERTEX) n_vertex++;
      else n_triangle++;
      if (e.word[136]) n_error++;
      expected_q.insert(expected_q.size(), e);
    endfunction

    task report(string what);
      mismatches++;
      $display("MISMATCH: %s", what);
    endtask

    task check_result(logic [135:0] data, logic err);
      mesh_expect_t want;
      logic [136:0] got;
      logic [63:0] g, w, mask;
      got = {err, data};
      if (expected_q.size() == 0) begin
        report($sformatf("result with no request pending, tdata %h tuser %b", data, err));
        return;
      end
      want = expected_q.pop_front();
      compared++;
      for (int i = 0; i < FIELD_COUNT; i++) begin
        mask = (64'd1 << FIELD_W[i]) - 64'd1;
        g = 64'(got >> FIELD_LSB[i]) & mask;
        w = 64'(want.word >> FIELD_LSB[i]) & mask;
        if (g !== w) begin
          report($sformatf("%s cmd %0d band %0d slice %0d half %0d radius %0d: got %0h want %0h",
                           field_name[i], want.req.cmd, want.req.band, want.req.slice,
                           want.req.half, radius, g, w));
        end
      end
    endtask

    task flag_leftovers();
      mesh_expect_t e;
      while (expected_q.size() != 0) begin
        e = expected_q.pop_front();
        report($sformatf("no result for cmd %0d band %0d slice %0d half %0d",
                         e.req.cmd, e.req.band, e.req.slice, e.req.half));
      end
    endtask
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [15:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic         m_axis_tuser;

  bit idling_on = 1'b1;
  int rx_hold_left = 0;
  int radius_settings = 0;
  mesh_scoreboard sb;

  uv_sphere_mesh_generator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  function automatic mesh_req_t make_req(cmd_e cmd, int band, int slice, bit half);
    mesh_req_t r;
    r.cmd   = cmd;
    r.band  = 7'(band);
    r.slice = 6'(slice);
    r.half  = half;
    return r;
  endfunction

  // Mostly in-range requests; the rest use the full width of every field.
  function automatic mesh_req_t random_request();
    mesh_req_t r;
    r.cmd  = cmd_e'($urandom_range(0, 1));
    r.half = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 85) begin
      if (r.cmd == CMD_VERTEX) begin
        r.band  = 7'($urandom_range(0, STACKS));
        r.slice = 6'($urandom_range(0, SLICES));
      end else begin
        r.band  = 7'($urandom_range(0, STACKS - 1));
        r.slice = 6'($urandom_range(0, SLICES - 1));
      end
    end else begin
      r.band  = 7'($urandom_range(0, 127));
      r.slice = 6'($urandom_range(0, 63));
    end
    return r;
  endfunction

  // Valid stays high after the transfer; the next call or a gap changes it.
  task automatic send_request(mesh_req_t req);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, req.half, req.slice, req.band};
    s_axis_tuser  <= req.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(req);
  endtask

  task automatic sender_gap(int cycles);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_radius(logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.radius = value;
    radius_settings++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic maybe_gap();
    if (idling_on && $urandom_range(0, 7) == 0) sender_gap($urandom_range(1, 18));
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_left--;
      end else if (idling_on && stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (idling_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 18);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    #1_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("uv_sphere_mesh_generator_top test failed");
    $finish;
  end

  initial begin
    logic [15:0] next_radius;
    sb = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: poles, ring and slice extremes, each triangle rule, out-of-range requests.
    send_request(make_req(CMD_VERTEX, 0, 63, 1'b0));
    send_request(make_req(CMD_VERTEX, STACKS, 0, 1'b1));
    send_request(make_req(CMD_VERTEX, 1, 0, 1'b0));
    send_request(make_req(CMD_VERTEX, STACKS - 1, SLICES, 1'b0));
    maybe_gap();
    send_request(make_req(CMD_VERTEX, 40, 10, 1'b0));
    send_request(make_req(CMD_VERTEX, 20, 30, 1'b1));
    send_request(make_req(CMD_VERTEX, STACKS + 1, 0, 1'b0));
    send_request(make_req(CMD_VERTEX, 127, 63, 1'b1));
    send_request(make_req(CMD_VERTEX, 5, SLICES + 1, 1'b0));
    send_request(make_req(CMD_VERTEX, 1, 63, 1'b0));
    maybe_gap();
    send_request(make_req(CMD_TRIANGLE, 0, 0, 1'b0));
    send_request(make_req(CMD_TRIANGLE, 0, SLICES - 1, 1'b1));
    send_request(make_req(CMD_TRIANGLE, 1, 0, 1'b0));
    send_request(make_req(CMD_TRIANGLE, 1, 0, 1'b1));
    send_request(make_req(CMD_TRIANGLE, STACKS - 2, SLICES - 1, 1'b1));
    send_request(make_req(CMD_TRIANGLE, 40, 20, 1'b0));
    maybe_gap();
    send_request(make_req(CMD_TRIANGLE, STACKS - 1, 0, 1'b0));
    send_request(make_req(CMD_TRIANGLE, STACKS - 1, SLICES - 1, 1'b1));
    send_request(make_req(CMD_TRIANGLE, STACKS, 0, 1'b0));
    send_request(make_req(CMD_TRIANGLE, 127, 5, 1'b1));
    send_request(make_req(CMD_TRIANGLE, 10, SLICES, 1'b0));
    send_request(make_req(CMD_TRIANGLE, 10, 63, 1'b1));
    wait_all_results();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: next_radius = 16'd1;
        1: next_radius = 16'hFFFF;
        2: next_radius = 16'd0;
        3: next_radius = 16'($urandom_range(2, 65534));
        4: next_radius = 16'h8000;
        default: next_radius = 16'd384;
      endcase
      write_radius(next_radius);
      @(posedge clk_i);
      // Back up the pipeline once while the sender keeps pushing.
      if (p == 1) rx_hold_left = 400;
      if (p == PHASES - 1) idling_on = 1'b0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        maybe_gap();
        send_request(random_request());
        if (p == 2 && i == ITEMS_PER_PHASE / 2) wait_all_results();
      end
      wait_all_results();
    end

    repeat (8) @(posedge clk_i);
    sb.flag_leftovers();
    $display("covered %0d vertex and %0d triangle requests, %0d out of range, over %0d radii",
             sb.n_vertex, sb.n_triangle, sb.n_error, radius_settings + 1);
    $display("%0d results compared, %0d field mismatches", sb.compared, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("uv_sphere_mesh_generator_top test passed");
    end else begin
      $display("uv_sphere_mesh_generator_top test failed");
    end
    $finish;
  end

endmodule
